[rtl/core/mlfr_pkg.sv]
`timescale 1ns / 1ps
// Package: shared types and constants of the marker/length frame receiver.
package mlfr_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_START_MARKER  = 2'd0;
    localparam logic [1:0] CFG_END_MARKER    = 2'd1;
    localparam logic [1:0] CFG_RESPONSE_TYPE = 2'd2;

    // Register reset values
    localparam logic [7:0] START_MARKER_RST  = 8'hFA;
    localparam logic [7:0] END_MARKER_RST    = 8'hF5;
    localparam logic [7:0] RESPONSE_TYPE_RST = 8'h02;

    // Checksum keeps the low seven bits of the running XOR
    localparam logic [7:0] CHECK_MASK = 8'h7F;

    // Frame byte positions: start, type, length, then payload
    localparam logic [8:0] POS_TYPE    = 9'd1;
    localparam logic [8:0] POS_LENGTH  = 9'd2;
    localparam logic [8:0] POS_PAYLOAD = 9'd3;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_END_ERR   = 2'd1,
        STS_CHECK_ERR = 2'd2,
        STS_TYPE_ERR  = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] start_marker;
        logic [7:0] end_marker;
        logic [7:0] response_type;
    } t_cfg;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        logic       frame_end;
        t_status    frame_status;
        logic [7:0] frame_type;
        logic [7:0] frame_length;
    } t_result;

endpackage

[rtl/core/mlfr_rx_if.sv]
`timescale 1ns / 1ps
// Interface: received byte channel.
interface mlfr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

[rtl/core/mlfr_res_if.sv]
`timescale 1ns / 1ps
// Interface: frame result channel.
interface mlfr_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic       frame_end;
    logic [1:0] frame_status;
    logic [7:0] frame_type;
    logic [7:0] frame_length;

    modport source (output valid, output payload_byte, output payload_index,
                    output frame_end, output frame_status, output frame_type,
                    output frame_length, input ready);
    modport sink   (input valid, input payload_byte, input payload_index,
                    input frame_end, input frame_status, input frame_type,
                    input frame_length, output ready);
endinterface

[rtl/core/mlfr_parser.sv]
`timescale 1ns / 1ps
// Module: frame state tracking, checksum and result formation for one byte.
module mlfr_parser
    import mlfr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_accept,
    input  logic [7:0] i_byte,
    input  t_cfg    i_cfg,
    output logic    o_res_valid,
    output t_result o_res
);

    logic       r_in_frame, n_in_frame;
    logic [8:0] r_pos,      n_pos;
    logic [7:0] r_type,     n_type;
    logic [7:0] r_length,   n_length;
    logic [7:0] r_xor,      n_xor;
    logic [7:0] r_check,    n_check;

    logic [8:0] check_pos;
    logic [7:0] index;
    t_status    status;

    assign check_pos = {1'b0, r_length} + POS_PAYLOAD;
    assign index     = 8'(r_pos - POS_PAYLOAD);

    always_comb begin
        priority if (i_byte != i_cfg.end_marker) begin
            status = STS_END_ERR;
        end else if ((r_xor & CHECK_MASK) != r_check) begin
            status = STS_CHECK_ERR;
        end else if (r_type != i_cfg.response_type) begin
            status = STS_TYPE_ERR;
        end else begin
            status = STS_OK;
        end
    end

    always_comb begin
        n_in_frame  = r_in_frame;
        n_pos       = r_pos;
        n_type      = r_type;
        n_length    = r_length;
        n_xor       = r_xor;
        n_check     = r_check;
        o_res_valid = 1'b0;
        o_res       = '{payload_byte: 8'd0, payload_index: 8'd0, frame_end: 1'b0,
                        frame_status: STS_OK, frame_type: r_type,
                        frame_length: r_length};
        if (i_accept) begin
            priority if (!r_in_frame) begin
                // drop everything but the start marker
                if (i_byte == i_cfg.start_marker) begin
                    n_in_frame = 1'b1;
                    n_pos      = POS_TYPE;
                    n_type     = 8'd0;
                    n_length   = 8'd0;
                    n_xor      = i_byte;
                    n_check    = 8'd0;
                end
            end else if (r_pos == POS_TYPE) begin
                n_type = i_byte;
                n_xor  = r_xor ^ i_byte;
                n_pos  = r_pos + 9'd1;
            end else if (r_pos == POS_LENGTH) begin
                n_length = i_byte;
                n_xor    = r_xor ^ i_byte;
                n_pos    = r_pos + 9'd1;
            end else if (r_pos < check_pos) begin
                n_xor                = r_xor ^ i_byte;
                n_pos                = r_pos + 9'd1;
                o_res_valid          = 1'b1;
                o_res.payload_byte   = i_byte;
                o_res.payload_index  = index;
            end else if (r_pos == check_pos) begin
                n_check = i_byte;
                n_pos   = r_pos + 9'd1;
            end else begin
                // closing byte: report and return to idle
                o_res_valid        = 1'b1;
                o_res.frame_end    = 1'b1;
                o_res.frame_status = status;
                n_in_frame         = 1'b0;
                n_pos              = 9'd0;
                n_type             = 8'd0;
                n_length           = 8'd0;
                n_xor              = 8'd0;
                n_check            = 8'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_pos      <= 9'd0;
            r_type     <= 8'd0;
            r_length   <= 8'd0;
            r_xor      <= 8'd0;
            r_check    <= 8'd0;
        end else begin
            r_in_frame <= n_in_frame;
            r_pos      <= n_pos;
            r_type     <= n_type;
            r_length   <= n_length;
            r_xor      <= n_xor;
            r_check    <= n_check;
        end
    end

endmodule

[rtl/core/marker_length_frame_receiver_top.sv]
`timescale 1ns / 1ps
// Top level: marker/length framed byte receiver with XOR checksum check.
//
//   Channel   Dir   Handshake        Carries
//   i_rx      in    valid/ready      rx_byte, one link byte per transfer
//   o_res     out   valid/ready      payload byte or closing frame status
//   i_cfg_*   in    write enable     start marker, end marker, response type
//
// One byte per cycle while the output is not stalled: each transfer is parsed in
// the cycle it is taken and any result lands in the output register on the same edge,
// so a result shows in the cycle after its byte. Frame state advances by compare, XOR and counter only.
// Reset (i_rst_n low, synchronous) returns to idle and restores register
// defaults. A stalled output holds its result; a new byte is still taken in
// the cycle the held result leaves.
module marker_length_frame_receiver_top
    import mlfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    mlfr_rx_if.sink    i_rx,
    mlfr_res_if.source o_res,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data
);

    t_cfg    r_cfg;
    logic    r_out_valid;
    t_result r_out;

    logic    accept;
    logic    res_valid;
    t_result res;

    // Take a byte whenever the output register is empty or draining now
    assign i_rx.ready = !r_out_valid || o_res.ready;
    assign accept     = i_rx.valid && i_rx.ready;

    // Configuration writes; an index past the list is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_marker  <= START_MARKER_RST;
            r_cfg.end_marker    <= END_MARKER_RST;
            r_cfg.response_type <= RESPONSE_TYPE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_START_MARKER:  r_cfg.start_marker  <= i_cfg_data;
                CFG_END_MARKER:    r_cfg.end_marker    <= i_cfg_data;
                CFG_RESPONSE_TYPE: r_cfg.response_type <= i_cfg_data;
                default: ;
            endcase
        end
    end

    mlfr_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_byte      (i_rx.rx_byte),
        .i_cfg       (r_cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Output register: load a new result, or drop the current one once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && res_valid) begin
            r_out <= res;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.payload_byte  = r_out.payload_byte;
    assign o_res.payload_index = r_out.payload_index;
    assign o_res.frame_end     = r_out.frame_end;
    assign o_res.frame_status  = r_out.frame_status;
    assign o_res.frame_type    = r_out.frame_type;
    assign o_res.frame_length  = r_out.frame_length;

endmodule

[sim/marker_length_frame_receiver_top_tb.sv]
`timescale 1ns / 1ps
// Testbench: frame receiver checked byte by byte against a parser model under random stalls.
module marker_length_frame_receiver_top_tb;
    import mlfr_pkg::*;

    // Index past the last register; the block must ignore writes to it
    localparam logic [1:0] CFG_SPARE_IDX = 2'd3;

    localparam int WATCHDOG_LIMIT     = 2000;
    localparam int DRAIN_CYCLES       = 6;
    localparam int RANDOM_BYTES       = 230;
    localparam int MAX_PRINTED_ERRORS = 40;

    typedef enum int {
        FRM_GOOD,
        FRM_BAD_END,
        FRM_BAD_CHECK,
        FRM_BAD_BOTH,
        FRM_CUT
    } t_frame_kind;

    logic       i_clk   = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [7:0] i_cfg_data;

    mlfr_rx_if  rx_ch ();
    mlfr_res_if res_ch ();

    marker_length_frame_receiver_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx       (rx_ch),
        .o_res      (res_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Register copies and frame parser state of the prediction
    logic [7:0] cfg_start;
    logic [7:0] cfg_end;
    logic [7:0] cfg_resp;
    logic       rcv_in_frame;
    logic [8:0] rcv_pos;
    logic [7:0] rcv_type;
    logic [7:0] rcv_len;
    logic [7:0] rcv_xor;
    logic [7:0] rcv_check;

    // Bytes waiting for the link, and the results they are predicted to cause
    logic [7:0] link_bytes[$];
    t_result    frame_results_due[$];
    logic [7:0] frame_body[$];

    int unsigned bytes_queued;
    int unsigned bytes_taken;
    int unsigned payload_seen;
    int unsigned frames_closed[4];
    int unsigned error_count;
    int unsigned idle_cycles;
    int unsigned src_idle_pct;
    int unsigned snk_idle_pct;
    bit          rx_took;

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTED_ERRORS) begin
            $display("ERROR at %0t ns: %s", $time, msg);
        end
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) begin
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
        end
    endtask

    task automatic clear_frame_state();
        rcv_in_frame = 1'b0;
        rcv_pos      = '0;
        rcv_type     = '0;
        rcv_len      = '0;
        rcv_xor      = '0;
        rcv_check    = '0;
    endtask

    // Advance the frame parser by one link byte; queue any result it causes
    task automatic parse_link_byte(input logic [7:0] b);
        t_result     r;
        int unsigned pos_i;
        int unsigned len_i;
        r     = '0;
        pos_i = rcv_pos;
        len_i = rcv_len;
        r.frame_type   = rcv_type;
        r.frame_length = rcv_len;
        if (!rcv_in_frame) begin
            if (b == cfg_start) begin
                clear_frame_state();
                rcv_in_frame = 1'b1;
                rcv_xor      = b;
                rcv_pos      = POS_TYPE;
            end
        end else if (rcv_pos == POS_TYPE) begin
            rcv_type = b;
            rcv_xor ^= b;
            rcv_pos++;
        end else if (rcv_pos == POS_LENGTH) begin
            rcv_len = b;
            rcv_xor ^= b;
            rcv_pos++;
        end else if (pos_i < POS_PAYLOAD + len_i) begin
            rcv_xor ^= b;
            r.payload_byte  = b;
            r.payload_index = 8'(pos_i - POS_PAYLOAD);
            r.frame_end     = 1'b0;
            r.frame_status  = STS_OK;
            frame_results_due.push_back(r);
            rcv_pos++;
        end else if (pos_i == POS_PAYLOAD + len_i) begin
            rcv_check = b;
            rcv_pos++;
        end else begin
            // Closing byte: end marker beats checksum, checksum beats type
            r.frame_end = 1'b1;
            if (b != cfg_end) begin
                r.frame_status = STS_END_ERR;
            end else if ((rcv_xor & CHECK_MASK) != rcv_check) begin
                r.frame_status = STS_CHECK_ERR;
            end else if (rcv_type != cfg_resp) begin
                r.frame_status = STS_TYPE_ERR;
            end else begin
                r.frame_status = STS_OK;
            end
            frame_results_due.push_back(r);
            clear_frame_state();
        end
    endtask

    task automatic add_byte(input logic [7:0] b);
        link_bytes.push_back(b);
        bytes_queued++;
    endtask

    // Queue one frame with frame_body as payload; a cut frame stops after the body
    task automatic add_frame(input t_frame_kind kind, input logic [7:0] ftype,
                             input logic [7:0] flen);
        logic [7:0] sum;
        sum = cfg_start ^ ftype ^ flen;
        add_byte(cfg_start);
        add_byte(ftype);
        add_byte(flen);
        foreach (frame_body[i]) begin
            add_byte(frame_body[i]);
            sum ^= frame_body[i];
        end
        if (kind != FRM_CUT) begin
            sum &= CHECK_MASK;
            if (kind == FRM_BAD_CHECK || kind == FRM_BAD_BOTH) begin
                // flipping bit 7 also probes the full-width checksum compare
                sum ^= 8'(1 << $urandom_range(0, 7));
            end
            add_byte(sum);
            if (kind == FRM_BAD_END || kind == FRM_BAD_BOTH) begin
                add_byte(cfg_end ^ 8'($urandom_range(1, 255)));
            end else begin
                add_byte(cfg_end);
            end
        end
    endtask

    // Mostly well-formed frames with random content; some noise and broken frames
    task automatic add_random_traffic(input int unsigned nbytes);
        int unsigned first;
        int unsigned flen;
        int unsigned body_len;
        int unsigned roll;
        logic [7:0]  nb;
        logic [7:0]  ftype;
        t_frame_kind kind;
        first = bytes_queued;
        while (bytes_queued - first < nbytes) begin
            if ($urandom_range(0, 99) < 15) begin
                repeat ($urandom_range(1, 3)) begin
                    nb = 8'($urandom);
                    add_byte((nb == cfg_start) ? ~nb : nb);
                end
            end
            flen  = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 48)
                                                 : $urandom_range(0, 12);
            ftype = ($urandom_range(0, 3) == 0) ? 8'($urandom) : cfg_resp;
            roll  = $urandom_range(0, 99);
            if (roll < 10)      kind = FRM_BAD_END;
            else if (roll < 20) kind = FRM_BAD_CHECK;
            else if (roll < 24) kind = FRM_BAD_BOTH;
            else if (roll < 29) kind = FRM_CUT;
            else                kind = FRM_GOOD;
            body_len = (kind == FRM_CUT) ? $urandom_range(0, flen) : flen;
            frame_body.delete();
            repeat (body_len) frame_body.push_back(8'($urandom));
            add_frame(kind, ftype, 8'(flen));
        end
    endtask

    // Write one register while the link is quiet and mirror it in the prediction
    task automatic write_register(input logic [1:0] idx, input logic [7:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_START_MARKER:  cfg_start = value;
            CFG_END_MARKER:    cfg_end   = value;
            CFG_RESPONSE_TYPE: cfg_resp  = value;
            default: ;
        endcase
    endtask

    // Hold until every byte went out and every result came back, then let the pipe settle
    task automatic wait_until_drained();
        while (link_bytes.size() != 0 || frame_results_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Driver: present the head of the byte queue; keep it until the transfer happens.
    // Result ready is rolled fresh every cycle.
    always @(negedge i_clk) begin
        if (i_rst_n && (!rx_ch.valid || rx_took)) begin
            if (link_bytes.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                rx_ch.valid   <= 1'b1;
                rx_ch.rx_byte <= link_bytes[0];
            end else begin
                rx_ch.valid   <= 1'b0;
            end
        end
        res_ch.ready <= i_rst_n && ($urandom_range(0, 99) >= snk_idle_pct);
    end

    // Monitor: take input transfers into the prediction, check each result transfer
    // against the oldest expectation, and watch for a stalled run.
    always @(posedge i_clk) begin
        t_result want;
        bit      any_transfer;
        any_transfer = 1'b0;
        rx_took      = i_rst_n && rx_ch.valid && rx_ch.ready;
        if (rx_took) begin
            parse_link_byte(rx_ch.rx_byte);
            void'(link_bytes.pop_front());
            bytes_taken++;
            any_transfer = 1'b1;
        end
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            any_transfer = 1'b1;
            if (frame_results_due.size() == 0) begin
                report_mismatch($sformatf("result with nothing expected: end %0b byte %0h",
                                          res_ch.frame_end, res_ch.payload_byte));
            end else begin
                want = frame_results_due.pop_front();
                check_field("payload_byte",  res_ch.payload_byte,  want.payload_byte);
                check_field("payload_index", res_ch.payload_index, want.payload_index);
                check_field("frame_end",     res_ch.frame_end,     want.frame_end);
                check_field("frame_status",  res_ch.frame_status,  want.frame_status);
                check_field("frame_type",    res_ch.frame_type,    want.frame_type);
                check_field("frame_length",  res_ch.frame_length,  want.frame_length);
            end
            if (res_ch.frame_end) begin
                frames_closed[res_ch.frame_status]++;
            end else begin
                payload_seen++;
            end
        end
        idle_cycles = any_transfer ? 0 : idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = '0;
        res_ch.ready  = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_START_MARKER;
        i_cfg_data    = '0;
        rx_took       = 1'b0;
        src_idle_pct  = 16;
        snk_idle_pct  = 46;
        cfg_start     = START_MARKER_RST;
        cfg_end       = END_MARKER_RST;
        cfg_resp      = RESPONSE_TYPE_RST;
        clear_frame_state();

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: idle noise at both extremes, empty payload, markers inside the
        // payload, unknown type, end error winning over checksum error, checksum error.
        add_byte(8'h00);
        add_byte(8'hFF);
        frame_body.delete();
        add_frame(FRM_GOOD, cfg_resp, 8'd0);
        frame_body = '{cfg_start, cfg_end};
        add_frame(FRM_GOOD, cfg_resp, 8'd2);
        frame_body = '{8'hFF};
        add_frame(FRM_GOOD, 8'h00, 8'd1);
        frame_body.delete();
        add_frame(FRM_BAD_BOTH, 8'hFF, 8'd0);
        add_frame(FRM_BAD_CHECK, cfg_resp, 8'd0);

        // Pause the sender until every result of the directed part is in
        wait_until_drained();
        add_random_traffic(RANDOM_BYTES);
        wait_until_drained();

        // Low/high extremes of all registers; the spare index must change nothing
        write_register(CFG_START_MARKER, 8'h00);
        write_register(CFG_END_MARKER, 8'hFF);
        write_register(CFG_RESPONSE_TYPE, 8'hFF);
        write_register(CFG_SPARE_IDX, 8'hA5);
        add_random_traffic(RANDOM_BYTES);
        wait_until_drained();

        // Swap the stall ratios and flip the register extremes
        src_idle_pct = 46;
        snk_idle_pct = 16;
        write_register(CFG_START_MARKER, 8'hFF);
        write_register(CFG_END_MARKER, 8'h00);
        write_register(CFG_RESPONSE_TYPE, 8'h00);
        add_random_traffic(RANDOM_BYTES);
        wait_until_drained();

        // No stalls at all; random register values and one longest frame
        src_idle_pct = 0;
        snk_idle_pct = 0;
        write_register(CFG_START_MARKER, 8'($urandom));
        write_register(CFG_END_MARKER, 8'($urandom));
        write_register(CFG_RESPONSE_TYPE, 8'($urandom));
        frame_body.delete();
        repeat (255) frame_body.push_back(8'($urandom));
        add_frame(FRM_GOOD, cfg_resp, 8'd255);
        add_random_traffic(RANDOM_BYTES);
        wait_until_drained();

        $display("Run covered %0d link bytes, %0d payload results, frames closed ok %0d,",
                 bytes_taken, payload_seen, frames_closed[STS_OK]);
        $display("end error %0d, checksum error %0d, unknown type %0d over four settings",
                 frames_closed[STS_END_ERR], frames_closed[STS_CHECK_ERR],
                 frames_closed[STS_TYPE_ERR]);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches", error_count);
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/mlfr_pkg.sv
rtl/core/mlfr_rx_if.sv
rtl/core/mlfr_res_if.sv
rtl/core/mlfr_parser.sv
rtl/core/marker_length_frame_receiver_top.sv
sim/marker_length_frame_receiver_top_tb.sv
